// ===== sv/brb_pkg.sv =====
// shared constants, types and helper functions for the byte ring buffer
package brb_pkg;

  localparam int DEPTH   = 256;
  localparam int MAX_RUN = 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = 9;
  localparam int LEN_W   = 7;
  localparam int FILL_W  = 8;
  localparam int DATA_W  = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_PEEK   = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic              full;
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              accepted;
    logic [LEN_W-1:0]  moved_count;
    logic              last;
    status_t           st;
  } res_t;

  typedef struct packed {
    logic use_ram;
    res_t res;
  } pend_t;

  function automatic logic [SW-1:0] clamp_size(logic [SW-1:0] v);
    logic [SW-1:0] r;
    if (v < SW'(2)) r = SW'(2);
    else if (v > SW'(DEPTH)) r = SW'(DEPTH);
    else r = v;
    return r;
  endfunction

  function automatic logic [AW-1:0] pos_inc(logic [AW-1:0] p, logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = SW'(p) + SW'(1);
    return (t == s) ? '0 : t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] pos_add(logic [AW-1:0] p, logic [LEN_W-1:0] n,
                                            logic [SW-1:0] s);
    logic [SW:0] t;
    t = (SW+1)'(p) + (SW+1)'(n);
    if (t >= (SW+1)'(s)) t = t - (SW+1)'(s);
    return t[AW-1:0];
  endfunction

  function automatic logic [SW-1:0] fill_of(logic [AW-1:0] rp, logic [AW-1:0] wp,
                                            logic [SW-1:0] s);
    logic [SW-1:0] f;
    if (wp >= rp) f = SW'(wp) - SW'(rp);
    else f = SW'(wp) + s - SW'(rp);
    return f;
  endfunction

  function automatic status_t status_of(logic [AW-1:0] rp, logic [AW-1:0] wp,
                                        logic [SW-1:0] s);
    status_t       st;
    logic [SW-1:0] f;
    f = fill_of(rp, wp, s);
    st.fill  = (f > SW'({FILL_W{1'b1}})) ? {FILL_W{1'b1}} : f[FILL_W-1:0];
    st.empty = (rp == wp);
    st.full  = (pos_inc(wp, s) == rp);
    return st;
  endfunction

endpackage

// ===== sv/brb_in_if.sv =====
// item channel: valid, ready and the request fields
interface brb_in_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [DATA_W-1:0] data_in;
  logic [LEN_W-1:0]  req_len;

  modport source (output valid, output op, output data_in, output req_len, input ready);
  modport sink   (input valid, input op, input data_in, input req_len, output ready);
endinterface

// ===== sv/brb_out_if.sv =====
// result channel: valid, ready and the result fields
interface brb_out_if;
  import brb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              accepted;
  logic [LEN_W-1:0]  moved_count;
  logic              last;
  logic [FILL_W-1:0] fill_level;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output data_out, output accepted, output moved_count,
                  output last, output fill_level, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input data_out, input accepted, input moved_count,
                  input last, input fill_level, input is_empty, input is_full,
                  output ready);
endinterface

// ===== sv/byte_ring_buffer_unit.sv =====
// top level of the byte ring buffer: front, command queue and back
//
// channel   | dir | handshake     | word
// items     | in  | valid/ready   | op, data_in, req_len
// results   | out | valid/ready   | data_out, accepted, moved_count, last, status
// cfg       | in  | cfg_wr_en     | cfg_wr_data, slots in use
//
// append and status-only words give a single result word each
// a peek or pop run of n bytes gives n words, one store read per cycle unless stalled
// a result passes the command queue, the pending register and the result queue
// rst clears pointers, queues and sets 256 slots in use; store is not cleared
// a stalled result side fills the two entry result queue, then the sequencer and
// then the command queue hold, and items is back-pressured
module byte_ring_buffer_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [brb_pkg::SW-1:0] cfg_wr_data,
  brb_in_if.sink                 items,
  brb_out_if.source              results
);
  import brb_pkg::*;

  logic cq_push, cq_full, cq_pop, cq_valid;
  cmd_t cq_in, cq_head;

  brb_front u_front (
    .items   (items),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_cmd  (cq_in)
  );

  brb_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cq_push),
    .push_cmd (cq_in),
    .full     (cq_full),
    .pop      (cq_pop),
    .valid    (cq_valid),
    .head     (cq_head)
  );

  brb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cq_valid    (cq_valid),
    .cq_cmd      (cq_head),
    .cq_pop      (cq_pop),
    .results     (results)
  );

endmodule

// ===== sv/brb_ram.sv =====
// generic single write port ram with registered read
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/brb_front.sv =====
// front end: takes items, decodes the op and clips the run length
module brb_front (
  brb_in_if.sink        items,
  input  logic          cq_full,
  output logic          cq_push,
  output brb_pkg::cmd_t cq_cmd
);
  import brb_pkg::*;

  assign items.ready = !cq_full;
  assign cq_push     = items.valid && !cq_full;

  always_comb begin
    cq_cmd.op   = op_t'(items.op);
    cq_cmd.data = items.data_in;
    cq_cmd.len  = (items.req_len > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : items.req_len;
  end

endmodule

// ===== sv/brb_cmd_queue.sv =====
// two entry command queue between front and back
module brb_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output brb_pkg::cmd_t head
);
  import brb_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always @(posedge clk) begin
    assert property (disable iff (rst) (pop |-> cnt != 2'd0))
      else $error("command queue popped while empty");
  end

endmodule

// ===== sv/brb_back.sv =====
// back end: ring pointers, byte store, run sequencer and result queue
module brb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [brb_pkg::SW-1:0] cfg_wr_data,
  input  logic                  cq_valid,
  input  brb_pkg::cmd_t         cq_cmd,
  output logic                  cq_pop,
  brb_out_if.source             results
);
  import brb_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t            state, state_next;
  logic [SW-1:0]     size_q;
  logic [AW-1:0]     rp, rp_next, wp, wp_next;
  logic [AW-1:0]     run_addr, run_addr_next;
  logic [LEN_W-1:0]  run_left, run_left_next;
  logic [LEN_W-1:0]  run_n, run_n_next;
  status_t           run_st, run_st_next;

  logic              pend_vld;
  pend_t             pend, iss;
  logic              issue;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  res_t              out_q [2];
  logic              out_wr, out_rd;
  logic [1:0]        out_cnt;
  logic              out_pop;
  res_t              land;
  logic [2:0]        credit;
  logic              can_issue;

  logic [SW-1:0]     cur_fill;
  logic              cur_full;
  logic [LEN_W-1:0]  n;
  logic [AW-1:0]     rp_after;
  status_t           st_after;

  brb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_pop   = results.valid && results.ready;
  assign credit    = 3'(out_cnt) + 3'(pend_vld) - 3'(out_pop);
  assign can_issue = (credit <= 3'd1);

  assign cur_fill = fill_of(rp, wp, size_q);
  assign cur_full = (pos_inc(wp, size_q) == rp);
  assign n        = (SW'(cq_cmd.len) > cur_fill) ? cur_fill[LEN_W-1:0] : cq_cmd.len;
  assign rp_after = (cq_cmd.op == OP_POP) ? pos_add(rp, n, size_q) : rp;
  assign st_after = status_of(rp_after, wp, size_q);

  always_comb begin
    state_next    = state;
    rp_next       = rp;
    wp_next       = wp;
    run_addr_next = run_addr;
    run_left_next = run_left;
    run_n_next    = run_n;
    run_st_next   = run_st;
    cq_pop        = 1'b0;
    issue         = 1'b0;
    iss           = '0;
    ram_we        = 1'b0;
    ram_waddr     = wp;
    ram_wdata     = cq_cmd.data;
    ram_re        = 1'b0;
    ram_raddr     = rp;
    unique case (state)
      S_IDLE: begin
        if (cq_valid && can_issue) begin
          cq_pop       = 1'b1;
          issue        = 1'b1;
          iss.res.last = 1'b1;
          iss.res.st   = status_of(rp, wp, size_q);
          unique case (cq_cmd.op)
            OP_APPEND: begin
              if (!cur_full) begin
                ram_we           = 1'b1;
                wp_next          = pos_inc(wp, size_q);
                iss.res.accepted = 1'b1;
                iss.res.st       = status_of(rp, pos_inc(wp, size_q), size_q);
              end
            end
            OP_PEEK, OP_POP: begin
              if (n != '0) begin
                rp_next             = rp_after;
                ram_re              = 1'b1;
                iss.use_ram         = 1'b1;
                iss.res.moved_count = n;
                iss.res.last        = (n == LEN_W'(1));
                iss.res.st          = st_after;
                if (n != LEN_W'(1)) begin
                  state_next    = S_RUN;
                  run_addr_next = pos_inc(rp, size_q);
                  run_left_next = n - LEN_W'(1);
                  run_n_next    = n;
                  run_st_next   = st_after;
                end
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (can_issue) begin
          issue               = 1'b1;
          ram_re              = 1'b1;
          ram_raddr           = run_addr;
          iss.use_ram         = 1'b1;
          iss.res.moved_count = run_n;
          iss.res.last        = (run_left == LEN_W'(1));
          iss.res.st          = run_st;
          run_addr_next       = pos_inc(run_addr, size_q);
          run_left_next       = run_left - LEN_W'(1);
          if (run_left == LEN_W'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    land          = pend.res;
    land.data_out = pend.use_ram ? ram_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (issue) pend <= iss;
    if (pend_vld) out_q[out_wr] <= land;
    run_addr <= run_addr_next;
    run_left <= run_left_next;
    run_n    <= run_n_next;
    run_st   <= run_st_next;
    if (rst) begin
      state    <= S_IDLE;
      size_q   <= SW'(DEPTH);
      rp       <= '0;
      wp       <= '0;
      pend_vld <= 1'b0;
      out_wr   <= 1'b0;
      out_rd   <= 1'b0;
      out_cnt  <= 2'd0;
    end else begin
      state    <= state_next;
      pend_vld <= issue;
      if (pend_vld) out_wr <= !out_wr;
      if (out_pop) out_rd <= !out_rd;
      out_cnt <= out_cnt + 2'(pend_vld) - 2'(out_pop);
      if (cfg_wr_en) begin
        size_q <= clamp_size(cfg_wr_data);
        rp     <= '0;
        wp     <= '0;
      end else begin
        rp <= rp_next;
        wp <= wp_next;
      end
    end
  end

  assign results.valid       = (out_cnt != 2'd0);
  assign results.data_out    = out_q[out_rd].data_out;
  assign results.accepted    = out_q[out_rd].accepted;
  assign results.moved_count = out_q[out_rd].moved_count;
  assign results.last        = out_q[out_rd].last;
  assign results.fill_level  = out_q[out_rd].st.fill;
  assign results.is_empty    = out_q[out_rd].st.empty;
  assign results.is_full     = out_q[out_rd].st.full;

  always @(posedge clk) begin
    assert property (disable iff (rst) (pend_vld |-> (out_cnt != 2'd2 || out_pop)))
      else $error("result queue overflow");
    assert property (disable iff (rst) (out_cnt <= 2'd2))
      else $error("result queue count out of range");
    assert property (disable iff (rst) (SW'(rp) < size_q && SW'(wp) < size_q))
      else $error("ring pointer beyond size in use");
    assert property (disable iff (rst) (state == S_RUN |-> run_left != '0))
      else $error("run active with nothing left");
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench for byte_ring_buffer_unit: directed and random words checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import brb_pkg::*;

  localparam longint RUN_LIMIT_NS = 64'd50_000_000;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [SW-1:0] cfg_wr_data;

  brb_in_if items_ch();
  brb_out_if results_ch();

  byte_ring_buffer_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .items(items_ch),
    .results(results_ch)
  );

  // predictor state
  logic [DATA_W-1:0] fifo_bytes [DEPTH];
  int rd_pos;
  int wr_pos;
  int slot_count;
  res_t expected_words [$];

  bit failed;
  bit no_idle;
  bit offering;
  bit hold_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("byte_ring_buffer_unit: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_slots(input logic [SW-1:0] v);
    if (v < 2) return 2;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  function automatic status_t status_now();
    status_t st;
    int f;
    f = (wr_pos >= rd_pos) ? wr_pos - rd_pos : wr_pos + slot_count - rd_pos;
    if (f > 255) f = 255;
    st.fill  = f[FILL_W-1:0];
    st.empty = (rd_pos == wr_pos);
    st.full  = (((wr_pos + 1) % slot_count) == rd_pos);
    return st;
  endfunction

  task automatic push_word(input logic [DATA_W-1:0] d, input logic acc,
                           input logic [LEN_W-1:0] n, input logic lst);
    res_t r;
    r.data_out    = d;
    r.accepted    = acc;
    r.moved_count = n;
    r.last        = lst;
    r.st          = status_now();
    expected_words.push_back(r);
  endtask

  task automatic predict_word(input op_t op, input logic [DATA_W-1:0] d,
                              input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] run [MAX_RUN];
    int n;
    int f;
    logic acc;
    case (op)
      OP_APPEND: begin
        acc = 1'b0;
        if (((wr_pos + 1) % slot_count) != rd_pos) begin
          fifo_bytes[wr_pos % DEPTH] = d;
          wr_pos = (wr_pos + 1) % slot_count;
          acc = 1'b1;
        end
        push_word('0, acc, '0, 1'b1);
      end
      OP_PEEK, OP_POP: begin
        n = int'(len);
        f = (wr_pos >= rd_pos) ? wr_pos - rd_pos : wr_pos + slot_count - rd_pos;
        if (n > MAX_RUN) n = MAX_RUN;
        if (n > f) n = f;
        for (int i = 0; i < n; i++) run[i] = fifo_bytes[((rd_pos + i) % slot_count) % DEPTH];
        if (op == OP_POP) rd_pos = (rd_pos + n) % slot_count;
        if (n == 0) begin
          push_word('0, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_word(run[i], 1'b0, LEN_W'(n), (i + 1 == n));
        end
      end
      default: begin
        push_word('0, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_word();
    res_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected result word, data_out %0d", results_ch.data_out);
      failed = 1'b1;
    end else begin
      e = expected_words.pop_front();
      if (results_ch.data_out !== e.data_out) begin
        $error("data_out exp %0d got %0d", e.data_out, results_ch.data_out);
        failed = 1'b1;
      end
      if (results_ch.accepted !== e.accepted) begin
        $error("accepted exp %0d got %0d", e.accepted, results_ch.accepted);
        failed = 1'b1;
      end
      if (results_ch.moved_count !== e.moved_count) begin
        $error("moved_count exp %0d got %0d", e.moved_count, results_ch.moved_count);
        failed = 1'b1;
      end
      if (results_ch.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, results_ch.last);
        failed = 1'b1;
      end
      if (results_ch.fill_level !== e.st.fill) begin
        $error("fill_level exp %0d got %0d", e.st.fill, results_ch.fill_level);
        failed = 1'b1;
      end
      if (results_ch.is_empty !== e.st.empty) begin
        $error("is_empty exp %0d got %0d", e.st.empty, results_ch.is_empty);
        failed = 1'b1;
      end
      if (results_ch.is_full !== e.st.full) begin
        $error("is_full exp %0d got %0d", e.st.full, results_ch.is_full);
        failed = 1'b1;
      end
    end
  endtask

  // predictor update and result check on every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) begin
        slot_count = clamp_slots(cfg_wr_data);
        rd_pos = 0;
        wr_pos = 0;
      end
      if (items_ch.valid && items_ch.ready)
        predict_word(op_t'(items_ch.op), items_ch.data_in, items_ch.req_len);
      if (results_ch.valid && results_ch.ready) check_word();
    end
  end

  // result side ready with random stalls and one long hold on request
  initial begin
    int busy;
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_results) begin
        results_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        busy = $urandom_range(1, 12);
        results_ch.ready <= 1'b1;
        repeat (busy) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          results_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic send_word(input op_t op, input logic [DATA_W-1:0] d,
                           input logic [LEN_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (offering) begin
        items_ch.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    items_ch.valid   <= 1'b1;
    items_ch.op      <= op;
    items_ch.data_in <= d;
    items_ch.req_len <= len;
    offering = 1'b1;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  // wait on the clock first so the word taken at the last edge is already predicted
  task automatic wait_all_results();
    if (offering) begin
      items_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [SW-1:0] v);
    wait_all_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_empty_runs();
    send_word(OP_PEEK, 8'h00, 7'd0);
    send_word(OP_POP, 8'hff, 7'd5);
    send_word(OP_PEEK, 8'h00, 7'd64);
    send_word(OP_NONE, 8'hff, 7'd127);
  endtask

  // size below range counts as two slots, one byte of room
  task automatic test_tiny_fifo();
    write_slot_count(9'd1);
    send_word(OP_APPEND, 8'h00, 7'd127);
    send_word(OP_APPEND, 8'hff, 7'd0);
    send_word(OP_PEEK, 8'h00, 7'd127);
    send_word(OP_POP, 8'h00, 7'd64);
    send_word(OP_POP, 8'h00, 7'd0);
    send_word(OP_APPEND, 8'hff, 7'd0);
    send_word(OP_APPEND, 8'h00, 7'd0);
    send_word(OP_POP, 8'h00, 7'd1);
  endtask

  task automatic test_three_slots();
    write_slot_count(9'd3);
    send_word(OP_APPEND, 8'ha5, 7'd0);
    send_word(OP_APPEND, 8'h5a, 7'd0);
    send_word(OP_APPEND, 8'h3c, 7'd0);
    send_word(OP_POP, 8'h00, 7'd1);
    send_word(OP_APPEND, 8'hc3, 7'd0);
    send_word(OP_PEEK, 8'h00, 7'd64);
    send_word(OP_POP, 8'h00, 7'd2);
  endtask

  task automatic test_oversize();
    write_slot_count(9'd511);
    send_word(OP_APPEND, 8'h81, 7'd0);
    send_word(OP_PEEK, 8'h00, 7'd1);
    write_slot_count(9'd257);
    send_word(OP_NONE, 8'h00, 7'd0);
  endtask

  // fill the 255 bytes of room in 256 slots, drain and wrap the write side
  task automatic test_full_depth();
    write_slot_count(9'd256);
    repeat (256) send_word(OP_APPEND, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    repeat (4) send_word(OP_POP, 8'($urandom_range(0, 255)), 7'd64);
    repeat (10) send_word(OP_APPEND, 8'($urandom_range(0, 255)), 7'd0);
  endtask

  // result side held off while long runs back up into the item side
  task automatic test_backpressure();
    no_idle = 1'b1;
    repeat (60) send_word(OP_APPEND, 8'($urandom_range(0, 255)), 7'd0);
    hold_results = 1'b1;
    repeat (10) send_word(OP_PEEK, 8'h00, 7'd64);
    repeat (2) send_word(OP_POP, 8'h00, 7'd64);
    repeat (5) send_word(OP_APPEND, 8'($urandom_range(0, 255)), 7'd0);
    no_idle = 1'b0;
    wait_all_results();
  endtask

  task automatic test_random_mix();
    logic [SW-1:0] sz;
    int r;
    logic [LEN_W-1:0] len;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: sz = SW'($urandom_range(3, 12));
        1: sz = 9'd0;
        2: sz = SW'($urandom_range(0, 511));
        3: sz = 9'd256;
        4: sz = SW'($urandom_range(13, 80));
        default: sz = SW'($urandom_range(257, 511));
      endcase
      write_slot_count(sz);
      no_idle = (p % 3 == 0);
      repeat (32) begin
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, MAX_RUN))
                                         : LEN_W'($urandom_range(0, 127));
        if (r < 55) send_word(OP_APPEND, 8'($urandom_range(0, 255)), len);
        else if (r < 70) send_word(OP_PEEK, 8'($urandom_range(0, 255)), len);
        else if (r < 94) send_word(OP_POP, 8'($urandom_range(0, 255)), len);
        else send_word(OP_NONE, 8'($urandom_range(0, 255)), len);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    failed = 1'b0;
    no_idle = 1'b0;
    offering = 1'b0;
    hold_results = 1'b0;
    slot_count = DEPTH;
    rd_pos = 0;
    wr_pos = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    items_ch.valid <= 1'b0;
    items_ch.op <= '0;
    items_ch.data_in <= '0;
    items_ch.req_len <= '0;
    results_ch.ready <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_runs();
    test_tiny_fifo();
    test_three_slots();
    test_oversize();
    test_full_depth();
    test_backpressure();
    test_random_mix();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("byte_ring_buffer_unit: match");
    end else begin
      $display("byte_ring_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule
